// ===== rtl/mfd_pkg.sv =====
// ============================================================================
// mfd_pkg
// Shared types, result codes and the frame length table of the MP3 deframer.
// ============================================================================
package mfd_pkg;

    localparam logic [7:0] SYNC_FIRST      = 8'hFF;
    localparam logic [7:0] SECOND_SYNC_RST = 8'hFB;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_BAD  = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    // what the datapath loads into the result register
    localparam logic [2:0] OSEL_FRAME_BYTE  = 3'd0;
    localparam logic [2:0] OSEL_BAD         = 3'd1;
    localparam logic [2:0] OSEL_DONE        = 3'd2;
    localparam logic [2:0] OSEL_SYNC_FF     = 3'd3;
    localparam logic [2:0] OSEL_SYNC_SECOND = 3'd4;
    localparam logic [2:0] OSEL_SYNC_HDR    = 3'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic        first_of_frame;
        logic        last_of_frame;
        logic [10:0] frame_length;
        logic        truncated;
    } t_out_item;

    typedef struct packed {
        logic       out_load;
        logic [2:0] out_sel;
        logic       load_second;
        logic       load_header;
        logic       dec_rem;
        logic       in_frame;
    } t_cmd;

    typedef struct packed {
        logic is_ff;
        logic is_second;
        logic hdr_bad;
        logic rem_zero;
        logic rem_one;
    } t_status;

    // 144 * kbps * 1000 / sample_rate, truncated; 0 for reserved codes
    function automatic logic [10:0] frame_len(input logic [3:0] bi, input logic [1:0] si);
        logic [10:0] len;
        len = 11'd0;
        case (si)
            2'd0: begin
                case (bi)
                    4'd1:    len = 11'd104;
                    4'd2:    len = 11'd130;
                    4'd3:    len = 11'd156;
                    4'd4:    len = 11'd182;
                    4'd5:    len = 11'd208;
                    4'd6:    len = 11'd261;
                    4'd7:    len = 11'd313;
                    4'd8:    len = 11'd365;
                    4'd9:    len = 11'd417;
                    4'd10:   len = 11'd522;
                    4'd11:   len = 11'd626;
                    4'd12:   len = 11'd731;
                    4'd13:   len = 11'd835;
                    4'd14:   len = 11'd1044;
                    default: len = 11'd0;
                endcase
            end
            2'd1: begin
                case (bi)
                    4'd1:    len = 11'd96;
                    4'd2:    len = 11'd120;
                    4'd3:    len = 11'd144;
                    4'd4:    len = 11'd168;
                    4'd5:    len = 11'd192;
                    4'd6:    len = 11'd240;
                    4'd7:    len = 11'd288;
                    4'd8:    len = 11'd336;
                    4'd9:    len = 11'd384;
                    4'd10:   len = 11'd480;
                    4'd11:   len = 11'd576;
                    4'd12:   len = 11'd672;
                    4'd13:   len = 11'd768;
                    4'd14:   len = 11'd960;
                    default: len = 11'd0;
                endcase
            end
            2'd2: begin
                case (bi)
                    4'd1:    len = 11'd144;
                    4'd2:    len = 11'd180;
                    4'd3:    len = 11'd216;
                    4'd4:    len = 11'd252;
                    4'd5:    len = 11'd288;
                    4'd6:    len = 11'd360;
                    4'd7:    len = 11'd432;
                    4'd8:    len = 11'd504;
                    4'd9:    len = 11'd576;
                    4'd10:   len = 11'd720;
                    4'd11:   len = 11'd864;
                    4'd12:   len = 11'd1008;
                    4'd13:   len = 11'd1152;
                    4'd14:   len = 11'd1440;
                    default: len = 11'd0;
                endcase
            end
            default: len = 11'd0;
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/mfd_stream_if.sv =====
// ============================================================================
// mfd_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ============================================================================
interface mfd_stream_if #(
    parameter type T = logic [7:0]
) ();
    logic valid;
    logic ready;
    T     data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/mp3_frame_deframer.sv =====
// ============================================================================
// mp3_frame_deframer
// MPEG-1 Layer III frame sync hunt, header decode and frame byte pass-out.
// ============================================================================
// The first result of an input transfer is registered as that transfer is taken.
// Throughput: one byte per cycle unless the output stalls; the header byte of a good
// frame yields three results and holds off input while they drain.
// Frame length comes from a constant table lookup on the header byte, no divider.
// Reset (synchronous, active low) returns to sync hunt with no result pending and
// restores the second sync byte to 0xFB.
module mp3_frame_deframer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    mfd_stream_if.sink          i_in,
    mfd_stream_if.source        o_out,
    mfd_stream_if.sink          i_cfg
);
    import mfd_pkg::*;

    t_cmd      cmd;
    t_status   status;
    t_in_item  in_item;
    t_out_item out_item;

    assign in_item     = i_in.data;
    assign o_out.data  = out_item;
    assign i_cfg.ready = 1'b1;

    mfd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_eos    (in_item.end_of_stream),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    mfd_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_byte   (in_item.data_byte),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (i_cfg.data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out       (out_item)
    );

endmodule

// ===== rtl/mfd_ctrl.sv =====
// ============================================================================
// mfd_ctrl
// Sync hunt / frame state machine and result register handshake control.
// ============================================================================
module mfd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_eos,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  mfd_pkg::t_status i_status,
    output mfd_pkg::t_cmd    o_cmd
);
    import mfd_pkg::*;

    localparam logic [1:0] PH_HUNT  = 2'd0;
    localparam logic [1:0] PH_FF    = 2'd1;
    localparam logic [1:0] PH_SYNC  = 2'd2;
    localparam logic [1:0] PH_FRAME = 2'd3;

    logic [1:0] r_phase, n_phase;
    logic [1:0] r_burst, n_burst;
    logic       r_out_valid, n_out_valid;
    logic       accept;
    logic       out_fire;
    t_cmd       cmd;

    assign o_in_ready  = (r_burst == 2'd0) && (!r_out_valid || i_out_ready);
    assign accept      = i_in_valid && o_in_ready;
    assign out_fire    = r_out_valid && i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    always_comb begin
        n_phase      = r_phase;
        n_burst      = r_burst;
        cmd          = '0;
        cmd.in_frame = (r_phase == PH_FRAME);
        if (accept) begin
            if (i_in_eos) begin
                cmd.out_load = 1'b1;
                cmd.out_sel  = OSEL_DONE;
                n_phase      = PH_HUNT;
            end else begin
                unique case (r_phase)
                    PH_HUNT: begin
                        if (i_status.is_ff) begin
                            n_phase = PH_FF;
                        end
                    end
                    PH_FF: begin
                        // match is tested first so a second byte of 0xFF still syncs
                        if (i_status.is_second) begin
                            cmd.load_second = 1'b1;
                            n_phase         = PH_SYNC;
                        end else if (!i_status.is_ff) begin
                            n_phase = PH_HUNT;
                        end
                    end
                    PH_SYNC: begin
                        cmd.out_load = 1'b1;
                        if (i_status.hdr_bad) begin
                            cmd.out_sel = OSEL_BAD;
                            n_phase     = i_status.is_ff ? PH_FF : PH_HUNT;
                        end else begin
                            cmd.out_sel     = OSEL_SYNC_FF;
                            cmd.load_header = 1'b1;
                            n_burst         = 2'd2;
                            n_phase         = PH_FRAME;
                        end
                    end
                    PH_FRAME: begin
                        if (i_status.rem_zero) begin
                            n_phase = i_status.is_ff ? PH_FF : PH_HUNT;
                        end else begin
                            cmd.out_load = 1'b1;
                            cmd.out_sel  = OSEL_FRAME_BYTE;
                            cmd.dec_rem  = 1'b1;
                            if (i_status.rem_one) begin
                                n_phase = PH_HUNT;
                            end
                        end
                    end
                    default: n_phase = PH_HUNT;
                endcase
            end
        end else if ((r_burst != 2'd0) && out_fire) begin
            // advance through the second sync byte and the header byte
            cmd.out_load = 1'b1;
            cmd.out_sel  = (r_burst == 2'd2) ? OSEL_SYNC_SECOND : OSEL_SYNC_HDR;
            n_burst      = r_burst - 2'd1;
        end
    end

    always_comb begin
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (out_fire) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_burst     <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_burst     <= n_burst;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/mfd_dpath.sv =====
// ============================================================================
// mfd_dpath
// Sync register, header decode, frame counters and the result register.
// ============================================================================
module mfd_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [7:0]         i_in_byte,
    input  logic               i_cfg_valid,
    input  logic [7:0]         i_cfg_data,
    input  mfd_pkg::t_cmd      i_cmd,
    output mfd_pkg::t_status   o_status,
    output mfd_pkg::t_out_item o_out
);
    import mfd_pkg::*;

    logic [7:0]  r_sync2;
    logic [7:0]  r_held_second, n_held_second;
    logic [7:0]  r_hdr_byte, n_hdr_byte;
    logic [10:0] r_cur_len, n_cur_len;
    logic [10:0] r_rem, n_rem;
    t_out_item   r_out, n_out;

    logic [3:0]  bi;
    logic [1:0]  si;
    logic [10:0] calc_len;
    logic        cut;

    assign bi       = i_in_byte[7:4];
    assign si       = i_in_byte[3:2];
    assign calc_len = frame_len(bi, si) + {10'd0, i_in_byte[1]};
    assign cut      = i_cmd.in_frame && (r_rem != 11'd0);

    assign o_status.is_ff     = (i_in_byte == SYNC_FIRST);
    assign o_status.is_second = (i_in_byte == r_sync2);
    assign o_status.hdr_bad   = (bi == 4'd0) || (bi == 4'd15) || (si == 2'd3);
    assign o_status.rem_zero  = (r_rem == 11'd0);
    assign o_status.rem_one   = (r_rem == 11'd1);

    assign o_out = r_out;

    always_comb begin
        n_held_second = i_cmd.load_second ? i_in_byte : r_held_second;
        n_hdr_byte    = i_cmd.load_header ? i_in_byte : r_hdr_byte;
        n_cur_len     = i_cmd.load_header ? calc_len : r_cur_len;
        if (i_cmd.load_header) begin
            n_rem = calc_len - 11'd3;
        end else if (i_cmd.dec_rem) begin
            n_rem = r_rem - 11'd1;
        end else begin
            n_rem = r_rem;
        end
    end

    always_comb begin
        n_out = r_out;
        if (i_cmd.out_load) begin
            n_out = '0;
            case (i_cmd.out_sel)
                OSEL_FRAME_BYTE: begin
                    n_out.kind          = KIND_BYTE;
                    n_out.out_byte      = i_in_byte;
                    n_out.last_of_frame = (r_rem == 11'd1);
                    n_out.frame_length  = r_cur_len;
                end
                OSEL_BAD: begin
                    n_out.kind = KIND_BAD;
                end
                OSEL_DONE: begin
                    n_out.kind         = KIND_DONE;
                    n_out.truncated    = cut;
                    n_out.frame_length = cut ? r_cur_len : 11'd0;
                end
                OSEL_SYNC_FF: begin
                    n_out.kind           = KIND_BYTE;
                    n_out.out_byte       = SYNC_FIRST;
                    n_out.first_of_frame = 1'b1;
                    n_out.frame_length   = calc_len;
                end
                OSEL_SYNC_SECOND: begin
                    n_out.kind         = KIND_BYTE;
                    n_out.out_byte     = r_held_second;
                    n_out.frame_length = r_cur_len;
                end
                OSEL_SYNC_HDR: begin
                    n_out.kind         = KIND_BYTE;
                    n_out.out_byte     = r_hdr_byte;
                    n_out.frame_length = r_cur_len;
                end
                default: n_out = r_out;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync2 <= SECOND_SYNC_RST;
        end else if (i_cfg_valid) begin
            r_sync2 <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held_second <= n_held_second;
        r_hdr_byte    <= n_hdr_byte;
        r_cur_len     <= n_cur_len;
        r_rem         <= n_rem;
        r_out         <= n_out;
    end

endmodule
